FILE: hdl/erp_pkg.sv
// Package for the range-reduced exponential pipeline.
// Holds field widths, default fractional formats, the fixed constants and
// the rounding helper that scales Q2.30 constants to the working format.
package erp_pkg;

    // Field widths of one input word and one result word.
    localparam int XW = 24;
    localparam int RW = 32;

    // Default fractional formats.
    localparam int INPUT_FRAC_BITS_DEF = 16;
    localparam int WORK_FRAC_BITS_DEF  = 30;

    // Constants in Q2.30; 1/ln2 is held as round(2^30/ln2).
    localparam logic signed [31:0] INV_LN2_Q30 = 32'sd1549082005;
    localparam longint LN2_Q30 = 744261118;
    localparam longint P0_Q30  = 1073741815;
    localparam longint P1_Q30  = 1073741888;
    localparam longint P2_Q30  = 536871572;
    localparam longint P3_Q30  = 178955935;
    localparam longint P4_Q30  = 44731969;
    localparam longint P5_Q30  = 8951718;
    localparam longint P6_Q30  = 1516409;
    localparam longint P7_Q30  = 210218;

    // IEEE single encoding details.
    localparam int EXP_BIAS = 127;
    localparam int EXP_INF  = 255;
    localparam logic [RW-1:0] FP_POS_INF = 32'h7F80_0000;
    localparam logic [RW-1:0] FP_POS_ZERO = 32'h0000_0000;

    // Rounds a Q2.30 constant half up to wfb fraction bits.
    function automatic longint qw(input longint c, input int wfb);
        longint sh;
        sh = longint'(30 - wfb);
        return (c + ((longint'(1) <<< sh) >>> 1)) >>> sh;
    endfunction

endpackage

FILE: hdl/erp_if.sv
// Channel interfaces of the range-reduced exponential pipeline.
// Each carries valid, ready and one word of payload; depends on erp_pkg.

interface erp_in_if
    import erp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] x_in;
    logic                 last_in;

    modport source (output valid, output x_in, output last_in, input ready);
    modport sink   (input valid, input x_in, input last_in, output ready);
endinterface

interface erp_out_if
    import erp_pkg::*;
();
    logic          valid;
    logic          ready;
    logic [RW-1:0] result_bits;
    logic          overflow;
    logic          underflow;
    logic          last_out;

    modport source (output valid, output result_bits, output overflow,
                    output underflow, output last_out, input ready);
    modport sink   (input valid, input result_bits, input overflow,
                    input underflow, input last_out, output ready);
endinterface

FILE: hdl/exp_range_reduced_polynomial.sv
// Range-reduced exponential: exp(x) = 2^n * p(t) packed as an IEEE single.
// Twelve-stage pipeline; depends on erp_pkg and the interfaces in erp_if.sv.
//
//  channel | direction | word contents                                    | handshake
//  --------+-----------+--------------------------------------------------+------------
//  arg     | in        | x_in (signed fixed point), last_in                | valid/ready
//  res     | out       | result_bits, overflow, underflow, last_out        | valid/ready
//
// Throughput is one word per clock while res is ready. The twelve register
// stages each hold at most one level of multipliers with an add, or one
// wide add, compare or shift.
// rst_n clears only the stage valid bits; data registers are not reset.
// Each stage advances when it is empty or the stage after it advances, so a
// stall on res fills bubbles first and arg.ready drops only when all stages
// hold a word. No word is dropped or duplicated during a stall.

module exp_range_reduced_polynomial
    import erp_pkg::*;
#(
    parameter int INPUT_FRAC_BITS = INPUT_FRAC_BITS_DEF,
    parameter int WORK_FRAC_BITS  = WORK_FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    erp_in_if.sink       arg,
    erp_out_if.source    res
);

    localparam int F   = INPUT_FRAC_BITS;
    localparam int W   = WORK_FRAC_BITS;
    localparam int NS  = 12;                 // pipeline depth
    localparam int PRW = XW + 32;            // x * (1/ln2) product
    localparam int SH  = F + 30;             // bits dropped to get n
    localparam int NW  = PRW - SH;           // width of n
    localparam int TW  = W + 2;              // working values, |v| < 2
    localparam int TFW = NW + W + 2;         // exact width of x - n*ln2
    localparam int PW  = TW + 2;             // polynomial sum
    localparam int UW  = PW - 1;             // magnitude of a positive sum
    localparam int LZW = $clog2(UW);
    localparam int NRW = UW + 25;            // left-aligned magnitude
    localparam int EW  = NW + 10;            // biased exponent with headroom
    // With the leading one at bit UW-1-lz, the biased exponent is n+EBASE-lz.
    localparam int EBASE = EXP_BIAS + UW - 1 - W;

    localparam logic [PRW-1:0] RBIAS = {{(PRW - SH){1'b0}}, {SH{1'b1}}};

    localparam logic signed [W:0]    LN2W = (W + 1)'(qw(LN2_Q30, W));
    localparam logic signed [TW-1:0] P0W  = TW'(qw(P0_Q30, W));
    localparam logic signed [TW-1:0] P1W  = TW'(qw(P1_Q30, W));
    localparam logic signed [TW-1:0] P2W  = TW'(qw(P2_Q30, W));
    localparam logic signed [TW-1:0] P3W  = TW'(qw(P3_Q30, W));
    localparam logic signed [TW-1:0] P4W  = TW'(qw(P4_Q30, W));
    localparam logic signed [TW-1:0] P5W  = TW'(qw(P5_Q30, W));
    localparam logic signed [TW-1:0] P6W  = TW'(qw(P6_Q30, W));
    localparam logic signed [TW-1:0] P7W  = TW'(qw(P7_Q30, W));

    // Fixed-point product, floored back to W fraction bits.
    function automatic logic signed [TW-1:0] wmul(input logic signed [TW-1:0] a,
                                                  input logic signed [TW-1:0] b);
        logic signed [2*TW-1:0] pr;
        pr = a * b;
        return pr[W+TW-1:W];
    endfunction

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its successor loads.
    // ------------------------------------------------------------------
    logic [NS-1:0] v_reg;
    logic [NS-1:0] last_reg;
    logic [NS:0]   en;

    always_comb
    begin
        en[NS] = res.ready;
        for (int i = NS - 1; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign arg.ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= arg.valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    // The batch marker rides along as a shift line beside the data.
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            last_reg[0] <= arg.last_in;
        end
        for (int i = 1; i < NS; i++)
        begin
            if (en[i])
            begin
                last_reg[i] <= last_reg[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Data path registers, one group per stage.
    // ------------------------------------------------------------------
    logic signed [XW-1:0]  x_s1_reg;
    logic signed [PRW-1:0] prod_s1_reg;
    logic signed [XW-1:0]  x_s2_reg;
    logic signed [NW-1:0]  n_s2_reg;
    logic signed [TW-1:0]  t_s3_reg;
    logic signed [NW-1:0]  n_s3_reg;
    logic signed [TW-1:0]  t_s4_reg, t2_s4_reg;
    logic signed [NW-1:0]  n_s4_reg;
    logic signed [TW-1:0]  t_s5_reg, t2_s5_reg, t3_s5_reg;
    logic signed [NW-1:0]  n_s5_reg;
    logic signed [TW-1:0]  t_s6_reg, t2_s6_reg, t3_s6_reg, t4_s6_reg;
    logic signed [NW-1:0]  n_s6_reg;
    logic signed [TW-1:0]  b0_s7_reg, b1_s7_reg, b2_s7_reg, b3_s7_reg;
    logic signed [TW-1:0]  t_s7_reg, t2_s7_reg, t3_s7_reg;
    logic signed [NW-1:0]  n_s7_reg;
    logic signed [TW-1:0]  a0_s8_reg, a1_s8_reg, a2_s8_reg, a3_s8_reg;
    logic signed [NW-1:0]  n_s8_reg;
    logic signed [PW-1:0]  p_s9_reg;
    logic signed [NW-1:0]  n_s9_reg;
    logic [UW-1:0]         u_s10_reg;
    logic [LZW-1:0]        lz_s10_reg;
    logic                  np_s10_reg;
    logic signed [NW-1:0]  n_s10_reg;
    logic [23:0]           mant_s11_reg;
    logic                  rnd_s11_reg;
    logic signed [EW-1:0]  e_s11_reg;
    logic                  np_s11_reg;
    logic [RW-1:0]         bits_reg;
    logic                  ovf_reg;
    logic                  unf_reg;

    // Next-value logic.
    logic signed [PRW-1:0] prod_next;
    logic signed [PRW-1:0] nsum;
    logic signed [NW-1:0]  n_next;
    logic signed [TFW-1:0] tfull;
    logic signed [TW-1:0]  t_next;
    logic signed [PW-1:0]  p_next;
    logic [UW-1:0]         u_next;
    logic [LZW-1:0]        lz_next;
    logic                  np_next;
    logic [NRW-1:0]        nrm;
    logic signed [EW-1:0]  e_next;
    logic [24:0]           m_rnd;
    logic                  m_carry;
    logic [22:0]           frac;
    logic signed [EW-1:0]  e_fin;
    logic [RW-1:0]         bits_next;
    logic                  ovf_next;
    logic                  unf_next;

    // Stage 1 and 2: n = trunc(x / ln2), toward zero.
    assign prod_next = PRW'(arg.x_in) * PRW'(INV_LN2_Q30);
    assign nsum      = prod_s1_reg + (prod_s1_reg[PRW-1] ? RBIAS : '0);
    assign n_next    = nsum[PRW-1:SH];

    // Stage 3: t = x - n*ln2 in the working format. |t| stays below one.
    assign tfull  = (TFW'(x_s2_reg) <<< (W - F)) - TFW'(n_s2_reg) * TFW'(LN2W);
    assign t_next = tfull[TW-1:0];

    // Stage 9: exact sum of the four partial terms.
    assign p_next = PW'(a0_s8_reg) + PW'(a1_s8_reg) + PW'(a2_s8_reg) + PW'(a3_s8_reg);

    // Stage 10: leading-one position of the positive sum.
    always_comb
    begin
        np_next = p_s9_reg[PW-1] || (p_s9_reg == '0);
        u_next  = p_s9_reg[UW-1:0];
        lz_next = '0;
        for (int i = 0; i < UW; i++)
        begin
            if (u_next[i])
            begin
                lz_next = LZW'(UW - 1 - i);
            end
        end
    end

    // Stage 11: left-align the magnitude and form the biased exponent.
    assign nrm    = {u_s10_reg, 25'b0} << lz_s10_reg;
    assign e_next = EW'(n_s10_reg) + EW'(EBASE) - EW'(lz_s10_reg);

    // Stage 12: round to nearest (ties up), renormalize, saturate and pack.
    always_comb
    begin
        m_rnd   = {1'b0, mant_s11_reg} + 25'(rnd_s11_reg);
        m_carry = m_rnd[24];
        frac    = m_carry ? m_rnd[23:1] : m_rnd[22:0];
        e_fin   = e_s11_reg + EW'(m_carry);
        ovf_next  = 1'b0;
        unf_next  = 1'b0;
        bits_next = {1'b0, e_fin[7:0], frac};
        if (np_s11_reg)
        begin
            unf_next  = 1'b1;
            bits_next = FP_POS_ZERO;
        end
        else if (e_fin >= EW'(EXP_INF))
        begin
            ovf_next  = 1'b1;
            bits_next = FP_POS_INF;
        end
        else if (e_fin < EW'(1))
        begin
            unf_next  = 1'b1;
            bits_next = FP_POS_ZERO;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_s1_reg    <= arg.x_in;
            prod_s1_reg <= prod_next;
        end
        if (en[1])
        begin
            x_s2_reg <= x_s1_reg;
            n_s2_reg <= n_next;
        end
        if (en[2])
        begin
            t_s3_reg <= t_next;
            n_s3_reg <= n_s2_reg;
        end
        if (en[3])
        begin
            t_s4_reg  <= t_s3_reg;
            t2_s4_reg <= wmul(t_s3_reg, t_s3_reg);
            n_s4_reg  <= n_s3_reg;
        end
        if (en[4])
        begin
            t_s5_reg  <= t_s4_reg;
            t2_s5_reg <= t2_s4_reg;
            t3_s5_reg <= wmul(t_s4_reg, t2_s4_reg);
            n_s5_reg  <= n_s4_reg;
        end
        if (en[5])
        begin
            t_s6_reg  <= t_s5_reg;
            t2_s6_reg <= t2_s5_reg;
            t3_s6_reg <= t3_s5_reg;
            t4_s6_reg <= wmul(t_s5_reg, t3_s5_reg);
            n_s6_reg  <= n_s5_reg;
        end
        if (en[6])
        begin
            b0_s7_reg <= P0W + wmul(t4_s6_reg, P4W);
            b1_s7_reg <= P1W + wmul(t4_s6_reg, P5W);
            b2_s7_reg <= P2W + wmul(t4_s6_reg, P6W);
            b3_s7_reg <= P3W + wmul(t4_s6_reg, P7W);
            t_s7_reg  <= t_s6_reg;
            t2_s7_reg <= t2_s6_reg;
            t3_s7_reg <= t3_s6_reg;
            n_s7_reg  <= n_s6_reg;
        end
        if (en[7])
        begin
            a0_s8_reg <= b0_s7_reg;
            a1_s8_reg <= wmul(b1_s7_reg, t_s7_reg);
            a2_s8_reg <= wmul(b2_s7_reg, t2_s7_reg);
            a3_s8_reg <= wmul(b3_s7_reg, t3_s7_reg);
            n_s8_reg  <= n_s7_reg;
        end
        if (en[8])
        begin
            p_s9_reg <= p_next;
            n_s9_reg <= n_s8_reg;
        end
        if (en[9])
        begin
            u_s10_reg  <= u_next;
            lz_s10_reg <= lz_next;
            np_s10_reg <= np_next;
            n_s10_reg  <= n_s9_reg;
        end
        if (en[10])
        begin
            mant_s11_reg <= nrm[NRW-1 -: 24];
            rnd_s11_reg  <= nrm[NRW-25];
            e_s11_reg    <= e_next;
            np_s11_reg   <= np_s10_reg;
        end
        if (en[11])
        begin
            bits_reg <= bits_next;
            ovf_reg  <= ovf_next;
            unf_reg  <= unf_next;
        end
    end

    assign res.valid       = v_reg[NS-1];
    assign res.result_bits = bits_reg;
    assign res.overflow    = ovf_reg;
    assign res.underflow   = unf_reg;
    assign res.last_out    = last_reg[NS-1];

endmodule
